[hdl/l2vn_pkg.sv]
package l2vn_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF      = 2048;
    localparam int ELEMENT_BITS_DEF = 24;

    // Fixed field widths
    localparam int ELEM_W   = 24;
    localparam int INDEX_W  = 11;
    localparam int CFG_W    = 12;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Arithmetic widths
    localparam int MAG_W  = ELEM_W;         // |element|, holds 2^(ELEM_W-1)
    localparam int SQ_W   = 2 * ELEM_W;     // exact square
    localparam int SUM_W  = 57;             // saturating sum of squares, Q.32
    localparam int NORM_W = 29;             // floor(sqrt(sum)), Q.16
    localparam int FRAC_W = 30;             // quotient fraction bits, Q1.30
    localparam int QUO_W  = FRAC_W + 1;     // quotient magnitude never exceeds 2^30

    localparam logic [CFG_W-1:0] VLEN_RESET = 12'd2048;

    // Response and load status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_NOT_READY = 2'd3
    } status_t;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACC  = 6'b000010,
        S_SQRT = 6'b000100,
        S_RD   = 6'b001000,
        S_DIV  = 6'b010000,
        S_PUSH = 6'b100000
    } state_t;

endpackage

[hdl/l2vn_ram.sv]
module l2vn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/l2vn_sqrt.sv]
module l2vn_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [l2vn_pkg::SUM_W-1:0]  radicand,
    output logic [l2vn_pkg::NORM_W-1:0] root,
    output logic                        done
);

    import l2vn_pkg::*;

    localparam int RAD_W = 2 * NORM_W;
    localparam int ITW   = $clog2(NORM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITW-1:0]    it_reg, it_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [NORM_W:0]   rem_reg, rem_next;
    logic [NORM_W-1:0] root_reg, root_next;
    logic [NORM_W+2:0] rem_sh, trial, diff;
    logic              fits;

    // Digit-by-digit root: two radicand bits in, one root bit out per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_sh - trial;
        fits      = (rem_sh >= trial);
        busy_next = busy_reg;
        done_next = 1'b0;
        it_next   = it_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            it_next   = '0;
            rad_next  = RAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = rad_reg << 2;
            rem_next  = fits ? diff[NORM_W:0] : rem_sh[NORM_W:0];
            root_next = {root_reg[NORM_W-2:0], fits};
            it_next   = it_reg + 1'b1;
            if (it_reg == ITW'(NORM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

[hdl/l2vn_div.sv]
module l2vn_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [l2vn_pkg::MAG_W-1:0]  magnitude,
    input  logic [l2vn_pkg::NORM_W-1:0] divisor,
    output logic [l2vn_pkg::QUO_W-1:0]  quotient,
    output logic                        done
);

    import l2vn_pkg::*;

    localparam int NUM_W = MAG_W + FRAC_W;
    localparam int ITW   = $clog2(QUO_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITW-1:0]    it_reg, it_next;
    logic [NORM_W-1:0] dvs_reg, dvs_next;
    logic [NORM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  low_reg, low_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [NUM_W-1:0]  num;
    logic [NORM_W:0]   rem_sh, diff;
    logic              ge;

    // Restoring division. The quotient fits QUO_W bits, so the top numerator
    // bits start out below the divisor and only QUO_W steps remain.
    always_comb
    begin
        num       = {magnitude, {FRAC_W{1'b0}}} + NUM_W'(divisor >> 1);
        rem_sh    = {rem_reg, low_reg[QUO_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        ge        = (rem_sh >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        it_next   = it_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            it_next   = '0;
            dvs_next  = divisor;
            rem_next  = NORM_W'(num[NUM_W-1:QUO_W]);
            low_next  = num[QUO_W-1:0];
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[NORM_W-1:0] : rem_sh[NORM_W-1:0];
            low_next = low_reg << 1;
            quo_next = {quo_reg[QUO_W-2:0], ge};
            it_next  = it_reg + 1'b1;
            if (it_reg == ITW'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[hdl/l2_vector_normalizer_core.sv]
// L2 vector normalizer.
// Input channel (in_valid / in_stall): operation 0 writes the next element
// (signed Q8.16) and adds its square to a saturating sum; last closes the
// vector. If the element count matches cfg_data as last written (reset 2048),
// the norm is taken by an iterative square root. operation 1 reads element
// index back as element/norm in Q1.30, or raw with a mismatch status.
// Output channel (out_valid / out_stall): one response per request.
// One request is worked on at a time; the element memory is accessed by that
// request only, so reads and writes never overlap.
// A closing write with a matching length runs 29 square-root steps, and a
// normalized read runs 31 restoring-division steps after the memory lookup;
// rejected, mismatch and zero-norm reads skip the division.
// The response sits in an output register: a stalled receiver holds it there
// while the next request is already accepted and worked on; that request
// then waits for the register before in_stall drops again.
// Reset clears count, sum and norm, marks the vector not ready and sets the
// length to 2048; the element memory is not cleared, and no entry is read
// before it was written in the current vector.
module l2_vector_normalizer_core #(
    parameter int MAX_DIM      = l2vn_pkg::MAX_DIM_DEF,
    parameter int ELEMENT_BITS = l2vn_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic signed [l2vn_pkg::ELEM_W-1:0]   element,
    input  logic                                 last,
    input  logic [l2vn_pkg::INDEX_W-1:0]         index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [l2vn_pkg::VALUE_W-1:0]  value,
    output logic [l2vn_pkg::STATUS_W-1:0]        status,
    output logic                                 normalized,
    input  logic                                 cfg_write,
    input  logic [l2vn_pkg::CFG_W-1:0]           cfg_data
);

    import l2vn_pkg::*;

    localparam int AW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW   = $clog2(MAX_DIM + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [NORM_W-1:0]   norm_reg, norm_next;
    status_t             ls_reg, ls_next;
    logic [CFG_W-1:0]    vlen_reg, vlen_next;
    logic                add_reg, add_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic                rd_neg_reg, rd_neg_next;
    logic [VALUE_W-1:0]  rs_value_reg, rs_value_next;
    status_t             rs_status_reg, rs_status_next;
    logic                rs_norm_reg, rs_norm_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    status_t             status_reg, status_next;
    logic                normalized_reg, normalized_next;

    logic                     accept, closed, full, rd_ok, len_match;
    logic [CW-1:0]            cnt_eff;
    logic signed [ELEM_W-1:0] el_sx, rd_sx;
    logic [MAG_W-1:0]         el_mag, rd_mag;
    logic [SQ_W-1:0]          sq_prod;
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_sat;
    logic                     ram_we, ram_re;
    logic [ELEMENT_BITS-1:0]  ram_rdata;
    logic                     sqrt_start, sqrt_done, div_start, div_done;
    logic [NORM_W-1:0]        sqrt_root;
    logic [QUO_W-1:0]         div_q;

    // Element memory
    l2vn_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (MAX_DIM)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_eff[AW-1:0]),
        .wdata (element[ELEMENT_BITS-1:0]),
        .re    (ram_re),
        .raddr (index[AW-1:0]),
        .rdata (ram_rdata)
    );

    l2vn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_next),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    l2vn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .magnitude (rd_mag),
        .divisor   (norm_reg),
        .quotient  (div_q),
        .done      (div_done)
    );

    // Request decode and datapath helpers
    always_comb
    begin
        accept    = in_valid && (state_reg == S_IDLE);
        closed    = (ls_reg == ST_OK) || (ls_reg == ST_MISMATCH);
        cnt_eff   = closed ? '0 : cnt_reg;
        full      = (cnt_eff == CW'(MAX_DIM));
        el_sx     = ELEM_W'(signed'(element[ELEMENT_BITS-1:0]));
        el_mag    = el_sx[ELEM_W-1] ? MAG_W'(-el_sx) : MAG_W'(el_sx);
        sq_prod   = el_mag * el_mag;
        rd_sx     = ELEM_W'(signed'(ram_rdata));
        rd_mag    = rd_sx[ELEM_W-1] ? MAG_W'(-rd_sx) : MAG_W'(rd_sx);
        sum_add   = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(sq_reg);
        sum_sat   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        rd_ok     = (ls_reg != ST_NOT_READY) && (ls_reg != ST_OVERFLOW)
                    && (CMPW'(index) < CMPW'(cnt_reg))
                    && (CMPW'(index) < CMPW'(MAX_DIM));
        len_match = (ls_reg != ST_OVERFLOW) && (CMPW'(cnt_reg) == CMPW'(vlen_reg));
        ram_we    = accept && !operation && !full;
        ram_re    = accept && operation && rd_ok;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        norm_next       = norm_reg;
        ls_next         = ls_reg;
        vlen_next       = cfg_write ? cfg_data : vlen_reg;
        add_next        = add_reg;
        last_next       = last_reg;
        sq_next         = sq_reg;
        rd_neg_next     = rd_neg_reg;
        rs_value_next   = rs_value_reg;
        rs_status_next  = rs_status_reg;
        rs_norm_next    = rs_norm_reg;
        out_valid_next  = out_valid_reg && out_stall;
        value_next      = value_reg;
        status_next     = status_reg;
        normalized_next = normalized_reg;
        sqrt_start      = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rs_value_next = '0;
                    rs_norm_next  = 1'b0;
                    if (!operation)
                    begin
                        // A write after a closed vector starts a new one
                        if (closed)
                        begin
                            ls_next  = ST_NOT_READY;
                            sum_next = '0;
                            cnt_next = '0;
                        end
                        if (full)
                        begin
                            ls_next        = ST_OVERFLOW;
                            rs_status_next = ST_OVERFLOW;
                            add_next       = 1'b0;
                        end
                        else
                        begin
                            cnt_next       = cnt_eff + 1'b1;
                            sq_next        = sq_prod;
                            add_next       = 1'b1;
                            rs_status_next = ST_OK;
                        end
                        last_next  = last;
                        state_next = S_ACC;
                    end
                    else if (rd_ok)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        rs_status_next = ST_NOT_READY;
                        state_next     = S_PUSH;
                    end
                end
            end

            S_ACC:
            begin
                if (add_reg)
                begin
                    sum_next = sum_sat;
                end
                state_next = S_PUSH;
                if (last_reg)
                begin
                    if (len_match)
                    begin
                        ls_next    = ST_OK;
                        sqrt_start = 1'b1;
                        state_next = S_SQRT;
                    end
                    else
                    begin
                        ls_next = ST_MISMATCH;
                    end
                end
            end

            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    norm_next  = sqrt_root;
                    state_next = S_PUSH;
                end
            end

            S_RD:
            begin
                // Memory data is valid in the cycle after the lookup
                if (ls_reg == ST_MISMATCH)
                begin
                    rs_value_next  = VALUE_W'(rd_sx);
                    rs_status_next = ST_MISMATCH;
                    state_next     = S_PUSH;
                end
                else
                begin
                    rs_status_next = ST_OK;
                    rs_norm_next   = 1'b1;
                    rd_neg_next    = rd_sx[ELEM_W-1];
                    if (norm_reg == '0)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    rs_value_next = rd_neg_reg ? -VALUE_W'(div_q) : VALUE_W'(div_q);
                    state_next    = S_PUSH;
                end
            end

            S_PUSH:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    value_next      = rs_value_reg;
                    status_next     = rs_status_reg;
                    normalized_next = rs_norm_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            norm_reg      <= '0;
            ls_reg        <= ST_NOT_READY;
            vlen_reg      <= VLEN_RESET;
            add_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            norm_reg      <= norm_next;
            ls_reg        <= ls_next;
            vlen_reg      <= vlen_next;
            add_reg       <= add_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        sq_reg         <= sq_next;
        rd_neg_reg     <= rd_neg_next;
        rs_value_reg   <= rs_value_next;
        rs_status_reg  <= rs_status_next;
        rs_norm_reg    <= rs_norm_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        normalized_reg <= normalized_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign value      = signed'(value_reg);
    assign status     = status_reg;
    assign normalized = normalized_reg;

endmodule

[hdl/l2vn_checker.sv]
module l2vn_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 operation,
    input logic signed [l2vn_pkg::ELEM_W-1:0]   element,
    input logic                                 last,
    input logic [l2vn_pkg::INDEX_W-1:0]         index,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [l2vn_pkg::VALUE_W-1:0]  value,
    input logic [l2vn_pkg::STATUS_W-1:0]        status,
    input logic                                 normalized,
    input logic                                 cfg_write,
    input logic [l2vn_pkg::CFG_W-1:0]           cfg_data
);

    import l2vn_pkg::*;

    // A stalled response holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status)
                                   && $stable(normalized))
        else $error("response changed while stalled");

    // One request at a time: an accepted request blocks the next cycle
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request accepted back to back");

    // Only an ok response carries a quotient
    a_norm_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && normalized |-> status == ST_OK)
        else $error("normalized flag on a non-ok response");

    // Rejected and dropped requests answer zero
    a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_READY || status == ST_OVERFLOW)
        |-> value == '0 && !normalized)
        else $error("nonzero value on a rejected request");

    // A quotient stays within unit magnitude in Q1.30
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && normalized
        |-> value <= 32'sd1073741824 && value >= -32'sd1073741824)
        else $error("normalized value out of range");

endmodule

bind l2_vector_normalizer_core l2vn_checker u_l2vn_checker (.*);
